[design/stpr_pkg.sv]
// Shared types and constants for the scope self-time profiler.
package stpr_pkg;

    localparam int unsigned TICK_W = 64;
    localparam int unsigned NAME_W = 7;
    localparam int unsigned CNT_W  = 32;

    localparam logic [29:0]       NS_PER_SEC = 30'd1000000000;
    localparam logic [TICK_W-1:0] FREQ_RESET = 64'd24000000;

    typedef enum logic [1:0] {
        CMD_ENTER  = 2'd0,
        CMD_COMMIT = 2'd1,
        CMD_FOLD   = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [NAME_W-1:0] name_id;
        logic [TICK_W-1:0] begin_ticks;
        logic [TICK_W-1:0] end_ticks;
    } stpr_in_t;

    typedef struct packed {
        logic [NAME_W-1:0] scope_name;
        logic [TICK_W-1:0] call_count;
        logic [TICK_W-1:0] inclusive_nanos;
        logic [TICK_W-1:0] self_nanos;
        logic [CNT_W-1:0]  frame_number;
        logic [CNT_W-1:0]  dropped_commits;
        logic              stack_overflowed;
        logic              entry_valid;
        logic              last_of_fold;
    } stpr_out_t;

    typedef struct packed {
        logic [TICK_W-1:0] calls;
        logic [TICK_W-1:0] incl_ticks;
        logic [TICK_W-1:0] self_ticks;
    } stpr_row_t;

    typedef struct packed {
        logic                start;
        logic [2*TICK_W-1:0] dividend;
        logic [TICK_W-1:0]   divisor;
    } stpr_div_req_t;

    typedef struct packed {
        logic              done;
        logic [TICK_W-1:0] quot;
        logic [TICK_W-1:0] rem;
    } stpr_div_rsp_t;

    typedef struct packed {
        logic              start;
        logic [TICK_W-1:0] ticks;
        logic [TICK_W-1:0] freq;
    } stpr_conv_req_t;

    typedef struct packed {
        logic              done;
        logic [TICK_W-1:0] nanos;
    } stpr_conv_rsp_t;

    typedef enum logic [3:0] {
        CV_IDLE,
        CV_QGO,
        CV_QWAIT,
        CV_MUL_RL,
        CV_MUL_RH,
        CV_FGO,
        CV_FWAIT,
        CV_MUL_QL,
        CV_MUL_QH,
        CV_DONE
    } conv_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CM_RD,
        ST_CM_UPD,
        ST_FD_RD,
        ST_FD_CHK,
        ST_FD_CI,
        ST_FD_CS,
        ST_FD_EMIT,
        ST_FD_END
    } top_state_t;

endpackage

[design/scope_self_time_profiler_unit.sv]
// Scope self-time profiler top level: stack, per-name accumulators, fold walker.
// Enter pushes the stack or flags overflow; commit does a stack and accumulator
// read-modify-write through memories with one read and one write port. Fold scans
// the name slots in order, reading then checking each; each slot with calls adds
// two tick-to-nanosecond conversions, set by the shared 1-bit-per-cycle divider
// that runs 128 steps twice per conversion, plus any time the output side stalls.
// The block takes no item until the current one is finished.
module scope_self_time_profiler_unit #(
    parameter int unsigned NAME_SLOTS  = 64,
    parameter int unsigned STACK_DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  stpr_pkg::stpr_in_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output stpr_pkg::stpr_out_t out_item,
    input  logic                cfg_we,
    input  logic [63:0]         cfg_wdata
);

    localparam int unsigned SW = (NAME_SLOTS > 1) ? $clog2(NAME_SLOTS) : 1;
    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
    localparam logic [DW-1:0] DEPTH_MAX = DW'(STACK_DEPTH);
    localparam logic [SW-1:0] SLOT_LAST = SW'(NAME_SLOTS - 1);
    localparam logic [6:0]    NAME_MAX  = 7'(NAME_SLOTS);

    stpr_pkg::top_state_t state_reg, state_next;

    logic [63:0]   freq_reg;
    logic [63:0]   freq_eff;
    logic [DW-1:0] depth_reg, depth_next;
    logic [31:0]   frame_reg, frame_next;
    logic [31:0]   drop_reg, drop_next;
    logic          ovf_reg, ovf_next;

    logic [63:0]   stack_mem [STACK_DEPTH];
    logic          stk_we;
    logic [AW-1:0] stk_waddr;
    logic [63:0]   stk_wdata;
    logic [AW-1:0] stk_raddr;
    logic [63:0]   stk_rdata_reg;
    logic [DW-1:0] depth_m1;
    logic [DW-1:0] depth_m2;

    stpr_pkg::stpr_row_t acc_mem [NAME_SLOTS];
    stpr_pkg::stpr_row_t acc_rdata_reg;
    stpr_pkg::stpr_row_t acc_base;
    stpr_pkg::stpr_row_t acc_wdata;
    logic [NAME_SLOTS-1:0] acc_vld_reg, acc_vld_next;
    logic                  acc_vld_rd_reg;
    logic                  acc_we;
    logic [SW-1:0]         acc_raddr;

    logic [SW-1:0] slot_reg, slot_next;
    logic          name_ok_reg, name_ok_next;
    logic [63:0]   incl_reg, incl_next;
    logic [63:0]   self_reg, self_next;
    logic [63:0]   child;
    logic [6:0]    in_name_m1;
    logic          in_name_ok;
    logic [63:0]   in_incl;
    logic [63:0]   fold_calls;

    stpr_pkg::stpr_row_t row_reg, row_next;
    logic [63:0]         incl_ns_reg, incl_ns_next;

    stpr_pkg::stpr_out_t pend_reg, pend_next;
    logic                pend_vld_reg, pend_vld_next;
    stpr_pkg::stpr_out_t out_reg, out_next;
    logic                out_vld_reg, out_vld_next;
    logic                out_free;
    stpr_pkg::stpr_out_t new_res;

    stpr_pkg::stpr_conv_req_t conv_req;
    stpr_pkg::stpr_conv_rsp_t conv_rsp;

    stpr_conv u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (conv_req),
        .rsp   (conv_rsp)
    );

    assign freq_eff   = (freq_reg == 64'd0) ? 64'd1 : freq_reg;
    assign depth_m1   = depth_reg - DW'(1);
    assign depth_m2   = depth_reg - DW'(2);
    assign in_name_m1 = in_item.name_id - 7'd1;
    assign in_name_ok = (in_item.name_id != 7'd0) && (in_item.name_id <= NAME_MAX);
    assign in_incl    = (in_item.end_ticks >= in_item.begin_ticks)
                        ? (in_item.end_ticks - in_item.begin_ticks) : 64'd0;
    assign child      = (depth_reg != DW'(0)) ? stk_rdata_reg : 64'd0;
    assign acc_base   = acc_vld_rd_reg ? acc_rdata_reg : '0;
    assign fold_calls = acc_base.calls;
    assign out_free   = !out_vld_reg || out_ready;
    assign in_ready   = (state_reg == stpr_pkg::ST_IDLE);

    always_comb
    begin
        acc_wdata.calls      = acc_base.calls + 64'd1;
        acc_wdata.incl_ticks = acc_base.incl_ticks + incl_reg;
        acc_wdata.self_ticks = acc_base.self_ticks + self_reg;

        new_res.scope_name       = 7'(slot_reg) + 7'd1;
        new_res.call_count       = row_reg.calls;
        new_res.inclusive_nanos  = incl_ns_reg;
        new_res.self_nanos       = conv_rsp.nanos;
        new_res.frame_number     = frame_reg;
        new_res.dropped_commits  = drop_reg;
        new_res.stack_overflowed = ovf_reg;
        new_res.entry_valid      = 1'b1;
        new_res.last_of_fold     = 1'b0;
    end

    always_comb
    begin
        state_next    = state_reg;
        depth_next    = depth_reg;
        frame_next    = frame_reg;
        drop_next     = drop_reg;
        ovf_next      = ovf_reg;
        slot_next     = slot_reg;
        name_ok_next  = name_ok_reg;
        incl_next     = incl_reg;
        self_next     = self_reg;
        row_next      = row_reg;
        incl_ns_next  = incl_ns_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        acc_vld_next  = acc_vld_reg;
        out_next      = out_reg;
        out_vld_next  = out_vld_reg && !out_ready;
        stk_we        = 1'b0;
        stk_waddr     = depth_reg[AW-1:0];
        stk_wdata     = 64'd0;
        stk_raddr     = depth_m1[AW-1:0];
        acc_we        = 1'b0;
        acc_raddr     = slot_reg;
        conv_req.start = 1'b0;
        conv_req.ticks = acc_base.incl_ticks;
        conv_req.freq  = freq_eff;
        case (state_reg)
            stpr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_item.command)
                        stpr_pkg::CMD_ENTER:
                        begin
                            if (depth_reg < DEPTH_MAX)
                            begin
                                stk_we     = 1'b1;
                                depth_next = depth_reg + DW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        stpr_pkg::CMD_COMMIT:
                        begin
                            slot_next    = in_name_m1[SW-1:0];
                            acc_raddr    = in_name_m1[SW-1:0];
                            name_ok_next = in_name_ok;
                            incl_next    = in_incl;
                            state_next   = stpr_pkg::ST_CM_RD;
                        end
                        stpr_pkg::CMD_FOLD:
                        begin
                            slot_next     = '0;
                            pend_vld_next = 1'b0;
                            state_next    = stpr_pkg::ST_FD_RD;
                        end
                        default:
                        begin
                            state_next = stpr_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            stpr_pkg::ST_CM_RD:
            begin
                stk_raddr  = depth_m2[AW-1:0];
                self_next  = (incl_reg >= child) ? (incl_reg - child) : 64'd0;
                if (depth_reg != DW'(0))
                begin
                    depth_next = depth_m1;
                end
                state_next = stpr_pkg::ST_CM_UPD;
            end
            stpr_pkg::ST_CM_UPD:
            begin
                if (depth_reg != DW'(0))
                begin
                    stk_we    = 1'b1;
                    stk_waddr = depth_m1[AW-1:0];
                    stk_wdata = stk_rdata_reg + incl_reg;
                end
                if (name_ok_reg)
                begin
                    acc_we                 = 1'b1;
                    acc_vld_next[slot_reg] = 1'b1;
                end
                else if (drop_reg != 32'hFFFF_FFFF)
                begin
                    drop_next = drop_reg + 32'd1;
                end
                state_next = stpr_pkg::ST_IDLE;
            end
            stpr_pkg::ST_FD_RD:
            begin
                state_next = stpr_pkg::ST_FD_CHK;
            end
            stpr_pkg::ST_FD_CHK:
            begin
                if (fold_calls != 64'd0)
                begin
                    row_next       = acc_base;
                    conv_req.start = 1'b1;
                    state_next     = stpr_pkg::ST_FD_CI;
                end
                else if (slot_reg == SLOT_LAST)
                begin
                    state_next = stpr_pkg::ST_FD_END;
                end
                else
                begin
                    slot_next  = slot_reg + SW'(1);
                    state_next = stpr_pkg::ST_FD_RD;
                end
            end
            stpr_pkg::ST_FD_CI:
            begin
                conv_req.ticks = row_reg.self_ticks;
                if (conv_rsp.done)
                begin
                    incl_ns_next   = conv_rsp.nanos;
                    conv_req.start = 1'b1;
                    state_next     = stpr_pkg::ST_FD_CS;
                end
            end
            stpr_pkg::ST_FD_CS:
            begin
                if (conv_rsp.done)
                begin
                    row_next.self_ticks = conv_rsp.nanos;
                    state_next          = stpr_pkg::ST_FD_EMIT;
                end
            end
            stpr_pkg::ST_FD_EMIT:
            begin
                if (!pend_vld_reg || out_free)
                begin
                    if (pend_vld_reg)
                    begin
                        out_next     = pend_reg;
                        out_vld_next = 1'b1;
                    end
                    pend_next            = new_res;
                    pend_next.self_nanos = row_reg.self_ticks;
                    pend_vld_next        = 1'b1;
                    acc_vld_next[slot_reg] = 1'b0;
                    if (slot_reg == SLOT_LAST)
                    begin
                        state_next = stpr_pkg::ST_FD_END;
                    end
                    else
                    begin
                        slot_next  = slot_reg + SW'(1);
                        state_next = stpr_pkg::ST_FD_RD;
                    end
                end
            end
            stpr_pkg::ST_FD_END:
            begin
                if (out_free)
                begin
                    if (pend_vld_reg)
                    begin
                        out_next = pend_reg;
                    end
                    else
                    begin
                        out_next                  = '0;
                        out_next.frame_number     = frame_reg;
                        out_next.dropped_commits  = drop_reg;
                        out_next.stack_overflowed = ovf_reg;
                    end
                    out_next.last_of_fold = 1'b1;
                    out_vld_next          = 1'b1;
                    pend_vld_next         = 1'b0;
                    frame_next            = frame_reg + 32'd1;
                    state_next            = stpr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stpr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= stpr_pkg::ST_IDLE;
            freq_reg     <= stpr_pkg::FREQ_RESET;
            depth_reg    <= '0;
            frame_reg    <= 32'd0;
            drop_reg     <= 32'd0;
            ovf_reg      <= 1'b0;
            acc_vld_reg  <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            if (cfg_we)
            begin
                freq_reg <= cfg_wdata;
            end
            depth_reg    <= depth_next;
            frame_reg    <= frame_next;
            drop_reg     <= drop_next;
            ovf_reg      <= ovf_next;
            acc_vld_reg  <= acc_vld_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg       <= slot_next;
        name_ok_reg    <= name_ok_next;
        incl_reg       <= incl_next;
        self_reg       <= self_next;
        row_reg        <= row_next;
        incl_ns_reg    <= incl_ns_next;
        pend_reg       <= pend_next;
        out_reg        <= out_next;
        acc_vld_rd_reg <= acc_vld_reg[acc_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        stk_rdata_reg <= stack_mem[stk_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            acc_mem[slot_reg] <= acc_wdata;
        end
        acc_rdata_reg <= acc_mem[acc_raddr];
    end

    assign out_valid = out_vld_reg;
    assign out_item  = out_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_MAX)
        else $error("stack depth beyond capacity");

    a_fold_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_item.command == stpr_pkg::CMD_FOLD)
        |=> state_reg == stpr_pkg::ST_FD_RD)
        else $error("fold did not start walk");

    a_fold_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == stpr_pkg::ST_FD_END && out_free)
        |=> out_vld_reg && out_reg.last_of_fold && state_reg == stpr_pkg::ST_IDLE)
        else $error("fold end lost final item");

    a_entry_calls: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_reg.entry_valid) |-> out_reg.call_count != 64'd0)
        else $error("reported scope without calls");

endmodule

[design/stpr_div.sv]
// Restoring divider, 128-bit dividend by 64-bit divisor, one bit per cycle.
module stpr_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  stpr_pkg::stpr_div_req_t req,
    output stpr_pkg::stpr_div_rsp_t rsp
);

    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic [127:0] dvd_reg, dvd_next;
    logic [63:0]  dsr_reg, dsr_next;
    logic [63:0]  rem_reg, rem_next;
    logic [63:0]  quo_reg, quo_next;
    logic [64:0]  shifted;
    logic [64:0]  diff;
    logic         ge;

    assign shifted = {rem_reg, dvd_reg[127]};
    assign ge      = shifted >= {1'b0, dsr_reg};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 7'd0;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = 64'd0;
            quo_next  = 64'd0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[63:0] : shifted[63:0];
            quo_next = {quo_reg[62:0], ge};
            dvd_next = {dvd_reg[126:0], 1'b0};
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd127)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

[design/stpr_conv.sv]
// Tick to nanosecond converter sequencing the shared divider and multiplier.
module stpr_conv (
    input  logic                    clk,
    input  logic                    rst_n,
    input  stpr_pkg::stpr_conv_req_t req,
    output stpr_pkg::stpr_conv_rsp_t rsp
);

    stpr_pkg::conv_state_t   state_reg, state_next;
    stpr_pkg::stpr_div_req_t div_req;
    stpr_pkg::stpr_div_rsp_t div_rsp;

    logic [63:0] t_reg, t_next;
    logic [63:0] f_reg, f_next;
    logic [63:0] q_reg, q_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] frac_reg, frac_next;
    logic [61:0] plo_reg, plo_next;
    logic [61:0] phi_reg, phi_next;
    logic [63:0] nanos_reg, nanos_next;
    logic        done_reg, done_next;
    logic [31:0] mul_op;
    logic [61:0] mul_prod;
    logic [93:0] frac_dvd;

    stpr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign mul_prod = 62'(mul_op) * 62'(stpr_pkg::NS_PER_SEC);
    assign frac_dvd = 94'(plo_reg) + {phi_reg, 32'd0};

    always_comb
    begin
        state_next       = state_reg;
        t_next           = t_reg;
        f_next           = f_reg;
        q_next           = q_reg;
        r_next           = r_reg;
        frac_next        = frac_reg;
        plo_next         = plo_reg;
        phi_next         = phi_reg;
        nanos_next       = nanos_reg;
        done_next        = 1'b0;
        mul_op           = 32'd0;
        div_req.start    = 1'b0;
        div_req.dividend = {64'd0, t_reg};
        div_req.divisor  = f_reg;
        case (state_reg)
            stpr_pkg::CV_IDLE:
            begin
                if (req.start)
                begin
                    t_next     = req.ticks;
                    f_next     = req.freq;
                    state_next = stpr_pkg::CV_QGO;
                end
            end
            stpr_pkg::CV_QGO:
            begin
                div_req.start = 1'b1;
                state_next    = stpr_pkg::CV_QWAIT;
            end
            stpr_pkg::CV_QWAIT:
            begin
                if (div_rsp.done)
                begin
                    q_next     = div_rsp.quot;
                    r_next     = div_rsp.rem;
                    state_next = stpr_pkg::CV_MUL_RL;
                end
            end
            stpr_pkg::CV_MUL_RL:
            begin
                mul_op     = r_reg[31:0];
                plo_next   = mul_prod;
                state_next = stpr_pkg::CV_MUL_RH;
            end
            stpr_pkg::CV_MUL_RH:
            begin
                mul_op     = r_reg[63:32];
                phi_next   = mul_prod;
                state_next = stpr_pkg::CV_FGO;
            end
            stpr_pkg::CV_FGO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = 128'(frac_dvd);
                state_next       = stpr_pkg::CV_FWAIT;
            end
            stpr_pkg::CV_FWAIT:
            begin
                if (div_rsp.done)
                begin
                    frac_next  = div_rsp.quot;
                    state_next = stpr_pkg::CV_MUL_QL;
                end
            end
            stpr_pkg::CV_MUL_QL:
            begin
                mul_op     = q_reg[31:0];
                plo_next   = mul_prod;
                state_next = stpr_pkg::CV_MUL_QH;
            end
            stpr_pkg::CV_MUL_QH:
            begin
                mul_op     = q_reg[63:32];
                phi_next   = mul_prod;
                state_next = stpr_pkg::CV_DONE;
            end
            stpr_pkg::CV_DONE:
            begin
                nanos_next = 64'(plo_reg) + {phi_reg[31:0], 32'd0} + frac_reg;
                done_next  = 1'b1;
                state_next = stpr_pkg::CV_IDLE;
            end
            default:
            begin
                state_next = stpr_pkg::CV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stpr_pkg::CV_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        f_reg     <= f_next;
        q_reg     <= q_next;
        r_reg     <= r_next;
        frac_reg  <= frac_next;
        plo_reg   <= plo_next;
        phi_reg   <= phi_next;
        nanos_reg <= nanos_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.nanos = nanos_reg;

endmodule
